[src/assert_macros.svh]
// Assertion macros for the RTL; only the top-level histogram file includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in a cycle, consequent holds in the same cycle.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent holds in a cycle, consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/wugh_pkg.sv]
// Package: types, register indexes and constants of the uniform grid histogram.
`default_nettype none
package wugh_pkg;

  localparam int NUM_BINS_DEF = 64;
  localparam int TALLY_W      = 48;
  localparam int BIN_IDX_W    = 6;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int NPTS_W       = 7;

  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_GRID_FRONT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_BACK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS  = 2'd3;

  localparam logic OP_ADD_HIT  = 1'b0;
  localparam logic OP_FINALIZE = 1'b1;

  localparam logic signed [31:0] GRID_FRONT_RST  = 32'sd0;
  localparam logic signed [31:0] GRID_BACK_RST   = 32'sd4128768;
  localparam logic [31:0]        INV_SPACING_RST = 32'd65536;
  localparam logic [NPTS_W-1:0]  NUM_POINTS_RST  = 7'd64;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] z_position;
    logic [31:0]        energy;
    logic [31:0]        norm;
  } in_item_t;

  typedef struct packed {
    logic [BIN_IDX_W-1:0] bin_index;
    logic [TALLY_W-1:0]   tally_value;
    logic                 last_bin;
  } out_item_t;

endpackage
`default_nettype wire

[src/wugh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wugh_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/weighted_uniform_grid_histogram.sv]
// Top level: weighted histogram of hit energies over a uniform grid of bins.
`default_nettype none
// After an add-hit beat is accepted, no new beat is accepted until it has
// passed position difference, reciprocal multiply, bin select with tally
// read, then add and write back through the single-port-pair tally RAM. A
// finalize beat sweeps all NUM_BINS tallies, each in turn through read, two
// 24x32 partial products, scale and write back, holding while the output
// stalls; it emits the first num_points bins (clamped to 2..NUM_BINS), last
// marked. Tallies read as zero after reset through per-bin valid flags, so
// no clearing pass is needed. Configure only while the block is idle.
module weighted_uniform_grid_histogram
  import wugh_pkg::*;
#(
  parameter int NUM_BINS = wugh_pkg::NUM_BINS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire wugh_pkg::in_item_t           in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output wugh_pkg::out_item_t               out_data,
  input  wire logic                         cfg_we,
  input  wire logic [wugh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [wugh_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wugh_pkg::*;
`include "assert_macros.svh"

  localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_BINS - 1);
  localparam logic [NPTS_W-1:0] NPTS_MAX = NPTS_W'(NUM_BINS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUB  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_BIN  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_FRD  = 3'd5;
  localparam logic [2:0] S_FMUL = 3'd6;
  localparam logic [2:0] S_FWR  = 3'd7;

  logic signed [31:0] grid_front_r;
  logic signed [31:0] grid_back_r;
  logic [31:0]        inv_spacing_r;
  logic [NPTS_W-1:0]  num_points_r;

  logic [2:0]          state_r, state_nxt;
  in_item_t            in_r;
  logic [31:0]         diff_r;
  logic                below_r, above_r;
  logic [63:0]         prod_r;
  logic [IDX_W-1:0]    bin_r, bin_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic [NUM_BINS-1:0] valid_r;
  logic [55:0]         phi_r, plo_r;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_r, out_nxt;

  logic [NPTS_W-1:0]   n_clamp;
  logic [IDX_W-1:0]    n_m1;
  logic [32:0]         diff_full;
  logic [31:0]         bin_raw;
  logic [TALLY_W-1:0]  rdata, tally_cur, wdata, scaled;
  logic [TALLY_W:0]    hit_sum, scale_sum;
  logic                mem_we, fwr_go;
  logic [IDX_W-1:0]    raddr, waddr;

  wugh_ram #(
    .WIDTH(TALLY_W),
    .DEPTH(NUM_BINS)
  ) u_tally_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    if (num_points_r < NPTS_W'(2)) begin
      n_clamp = NPTS_W'(2);
    end else if (num_points_r > NPTS_MAX) begin
      n_clamp = NPTS_MAX;
    end else begin
      n_clamp = num_points_r;
    end
  end
  assign n_m1 = IDX_W'(n_clamp - NPTS_W'(1));

  assign diff_full = {in_r.z_position[31], in_r.z_position}
                   - {grid_front_r[31], grid_front_r};
  assign bin_raw = prod_r[63:32];

  always_comb begin
    if (below_r) begin
      bin_nxt = '0;
    end else if (above_r) begin
      bin_nxt = n_m1;
    end else if (bin_raw > 32'(n_m1)) begin
      bin_nxt = n_m1;
    end else begin
      bin_nxt = IDX_W'(bin_raw);
    end
  end

  assign tally_cur = (state_r == S_ADD) ? (valid_r[bin_r] ? rdata : '0)
                                        : (valid_r[cnt_r] ? rdata : '0);
  assign hit_sum   = {1'b0, tally_cur} + {{(TALLY_W-31){1'b0}}, in_r.energy};

  assign scale_sum = {1'b0, phi_r[39:0], 8'd0} + {9'd0, plo_r[55:16]};
  always_comb begin
    if (phi_r[55:40] != '0) begin
      scaled = TALLY_MAX;
    end else if (scale_sum[TALLY_W]) begin
      scaled = TALLY_MAX;
    end else begin
      scaled = scale_sum[TALLY_W-1:0];
    end
  end

  assign fwr_go = (state_r == S_FWR) && !(out_valid_r && out_stall);
  assign mem_we = (state_r == S_ADD) || fwr_go;
  assign waddr  = (state_r == S_ADD) ? bin_r : cnt_r;
  assign raddr  = (state_r == S_BIN) ? bin_nxt : cnt_r;
  assign wdata  = (state_r == S_ADD)
                ? (hit_sum[TALLY_W] ? TALLY_MAX : hit_sum[TALLY_W-1:0])
                : scaled;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.operation == OP_FINALIZE) ? S_FRD : S_SUB;
          cnt_nxt   = '0;
        end
      end
      S_SUB:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_BIN;
      S_BIN:  state_nxt = S_ADD;
      S_ADD:  state_nxt = S_IDLE;
      S_FRD:  state_nxt = S_FMUL;
      S_FMUL: state_nxt = S_FWR;
      S_FWR: begin
        if (fwr_go) begin
          if (cnt_r <= n_m1) begin
            out_valid_nxt     = 1'b1;
            out_nxt.bin_index = BIN_IDX_W'(cnt_r);
            out_nxt.tally_value = scaled;
            out_nxt.last_bin  = (cnt_r == n_m1);
          end
          if (cnt_r == IDX_LAST) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + IDX_W'(1);
            state_nxt = S_FRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      valid_r       <= '0;
      cnt_r         <= '0;
      grid_front_r  <= GRID_FRONT_RST;
      grid_back_r   <= GRID_BACK_RST;
      inv_spacing_r <= INV_SPACING_RST;
      num_points_r  <= NUM_POINTS_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (state_r == S_ADD) begin
        valid_r[bin_r] <= 1'b1;
      end
      if (fwr_go) begin
        valid_r[cnt_r] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_FRONT:  grid_front_r  <= cfg_data;
          REG_GRID_BACK:   grid_back_r   <= cfg_data;
          REG_INV_SPACING: inv_spacing_r <= cfg_data;
          REG_NUM_POINTS:  num_points_r  <= cfg_data[NPTS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (state_r == S_IDLE && in_valid) begin
      in_r <= in_data;
    end
    if (state_r == S_SUB) begin
      diff_r  <= diff_full[31:0];
      below_r <= (in_r.z_position <= grid_front_r);
      above_r <= (in_r.z_position >= grid_back_r);
    end
    if (state_r == S_MUL) begin
      prod_r <= {32'd0, diff_r} * {32'd0, inv_spacing_r};
    end
    if (state_r == S_BIN) begin
      bin_r <= bin_nxt;
    end
    if (state_r == S_FMUL) begin
      phi_r <= {8'd0, tally_cur[TALLY_W-1:24]} * {24'd0, in_r.norm};
      plo_r <= {8'd0, tally_cur[23:0]} * {24'd0, in_r.norm};
    end
  end

  `ASSERT_NEXT(a_hit_starts, in_valid && !in_stall && in_data.operation == OP_ADD_HIT,
               state_r == S_SUB, "accepted hit did not start the bin pipeline")
  `ASSERT_NEXT(a_sweep_holds, state_r == S_FWR && out_valid_r && out_stall,
               state_r == S_FWR && $stable(cnt_r), "sweep advanced past a held result")
  `ASSERT_NEXT(a_sweep_ends, fwr_go && cnt_r == IDX_LAST,
               state_r == S_IDLE, "sweep did not end after the last stored bin")

endmodule
`default_nettype wire
